// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Stable priority queue package
// Field widths, status codes, command codes and sequencer states.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int PRIO_W        = 32;
    localparam int VALUE_W       = 32;
    localparam int ENTRY_W       = PRIO_W + VALUE_W;
    localparam int STATUS_W      = 2;
    localparam int OCC_W         = 5;
    localparam int CAPACITY_DEF  = 16;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_REMOVED   = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CMP,
        S_RDFRONT,
        S_EMIT
    } state_t;

endpackage

// ===== sv/spq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
    parameter int WIDTH = spq_pkg::ENTRY_W,
    parameter int DEPTH = spq_pkg::CAPACITY_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Stable priority queue
// Bounded queue kept in sorted order in a circular RAM buffer.
// ----------------------------------------------------------------------------
// Entries are held front first in a circular buffer in one RAM. A remove
// reads the front slot and advances the head pointer. An insert walks back
// from the tail: each held entry whose priority number is larger than the
// new one costs one RAM read, one compare and one write that moves it up a
// slot. Equal priorities keep arrival order, and req_stall stays high while
// an item is in progress.
module stable_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic                                cmd,
    input  logic signed [spq_pkg::VALUE_W-1:0]  item_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]   priority_req,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic        [spq_pkg::STATUS_W-1:0] status,
    output logic signed [spq_pkg::VALUE_W-1:0]  removed_value,
    output logic signed [spq_pkg::PRIO_W-1:0]   removed_priority,
    output logic        [spq_pkg::OCC_W-1:0]    occupancy
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    spq_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    idx_reg, idx_next;

    logic signed [spq_pkg::PRIO_W-1:0]  pri_reg, pri_next;
    logic signed [spq_pkg::VALUE_W-1:0] val_reg, val_next;

    spq_pkg::status_t                   res_status_reg, res_status_next;
    logic signed [spq_pkg::VALUE_W-1:0] res_value_reg, res_value_next;
    logic signed [spq_pkg::PRIO_W-1:0]  res_prio_reg, res_prio_next;

    logic                               out_valid_reg, out_valid_next;
    spq_pkg::status_t                   out_status_reg, out_status_next;
    logic signed [spq_pkg::VALUE_W-1:0] out_value_reg, out_value_next;
    logic signed [spq_pkg::PRIO_W-1:0]  out_prio_reg, out_prio_next;
    logic [spq_pkg::OCC_W-1:0]          out_occ_reg, out_occ_next;

    logic                               wr_en;
    logic [AW-1:0]                      wr_addr;
    logic [spq_pkg::ENTRY_W-1:0]        wr_data;
    logic                               rd_en;
    logic [AW-1:0]                      rd_addr;
    logic [spq_pkg::ENTRY_W-1:0]        rd_data;
    logic signed [spq_pkg::PRIO_W-1:0]  rd_prio;
    logic signed [spq_pkg::VALUE_W-1:0] rd_value;

    logic [AW:0]   slot_sum;
    logic [AW-1:0] slot_idx;
    logic [AW-1:0] slot_prev;
    logic [AW-1:0] head_inc;
    logic          out_free;

    // Physical slot of logical position idx_reg, and the slot just before it.
    assign slot_sum  = {1'b0, head_reg} + {1'b0, idx_reg};
    assign slot_idx  = (slot_sum >= (AW+1)'(CAPACITY)) ?
                       AW'(slot_sum - (AW+1)'(CAPACITY)) : AW'(slot_sum);
    assign slot_prev = (slot_idx == '0) ? AW'(CAPACITY - 1) : slot_idx - AW'(1);
    assign head_inc  = (head_reg == AW'(CAPACITY - 1)) ? '0 : head_reg + AW'(1);

    assign rd_prio  = rd_data[spq_pkg::ENTRY_W-1:spq_pkg::VALUE_W];
    assign rd_value = rd_data[spq_pkg::VALUE_W-1:0];

    assign out_free = !out_valid_reg || !rsp_stall;

    spq_ram #(
        .WIDTH (spq_pkg::ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spq_pkg::S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        pri_reg        <= pri_next;
        val_reg        <= val_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_prio_reg   <= res_prio_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_prio_reg   <= out_prio_next;
        out_occ_reg    <= out_occ_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        idx_next        = idx_reg;
        pri_next        = pri_reg;
        val_next        = val_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_prio_next   = res_prio_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_prio_next   = out_prio_reg;
        out_occ_next    = out_occ_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        wr_en           = 1'b0;
        wr_addr         = slot_idx;
        wr_data         = {pri_reg, val_reg};
        rd_en           = 1'b0;
        rd_addr         = slot_prev;
        req_stall       = 1'b1;

        unique case (state_reg)
            spq_pkg::S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    res_value_next = '0;
                    res_prio_next  = '0;
                    pri_next       = priority_req;
                    val_next       = item_value;
                    if (cmd == spq_pkg::CMD_REMOVE)
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = spq_pkg::ST_UNDERFLOW;
                            state_next      = spq_pkg::S_EMIT;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg;
                            state_next = spq_pkg::S_RDFRONT;
                        end
                    end
                    else
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            res_status_next = spq_pkg::ST_OVERFLOW;
                            state_next      = spq_pkg::S_EMIT;
                        end
                        else
                        begin
                            idx_next   = AW'(count_reg);
                            state_next = spq_pkg::S_SCAN;
                        end
                    end
                end
            end

            spq_pkg::S_SCAN:
            begin
                if (idx_reg == '0)
                begin
                    wr_en           = 1'b1;
                    count_next      = count_reg + CNT_W'(1);
                    res_status_next = spq_pkg::ST_INSERTED;
                    state_next      = spq_pkg::S_EMIT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = spq_pkg::S_CMP;
                end
            end

            spq_pkg::S_CMP:
            begin
                wr_en = 1'b1;
                if (rd_prio > pri_reg)
                begin
                    // The held entry ranks behind the new one: move it up a slot.
                    wr_data    = rd_data;
                    idx_next   = idx_reg - AW'(1);
                    state_next = spq_pkg::S_SCAN;
                end
                else
                begin
                    count_next      = count_reg + CNT_W'(1);
                    res_status_next = spq_pkg::ST_INSERTED;
                    state_next      = spq_pkg::S_EMIT;
                end
            end

            spq_pkg::S_RDFRONT:
            begin
                res_value_next  = rd_value;
                res_prio_next   = rd_prio;
                res_status_next = spq_pkg::ST_REMOVED;
                head_next       = head_inc;
                count_next      = count_reg - CNT_W'(1);
                state_next      = spq_pkg::S_EMIT;
            end

            spq_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = res_value_reg;
                    out_prio_next   = res_prio_reg;
                    out_occ_next    = spq_pkg::OCC_W'(count_reg);
                    state_next      = spq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = spq_pkg::S_IDLE;
            end
        endcase
    end

    assign rsp_valid        = out_valid_reg;
    assign status           = out_status_reg;
    assign removed_value    = out_value_reg;
    assign removed_priority = out_prio_reg;
    assign occupancy        = out_occ_reg;

endmodule
